// ===== design/dssm_pkg.sv =====
// Shared types and constants for the dual stack shared memory block.
`default_nettype none

package dssm_pkg;

   localparam int DEFAULT_DEPTH = 256;
   localparam int QUEUE_DEPTH   = 2;
   localparam int WORD_WIDTH    = 32;

   typedef enum logic [1:0] {
      OP_PUSH_ONE = 2'd0,
      OP_PUSH_TWO = 2'd1,
      OP_POP_ONE  = 2'd2,
      OP_POP_TWO  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      status_type status;
   } ctrl_type;

   localparam int CTRL_WIDTH = $bits(ctrl_type);

endpackage

`default_nettype wire

// ===== design/dssm_front.sv =====
// Front end: accepts operations, owns both stack counts, issues memory commands.
`default_nettype none

module dssm_front #(
   parameter int DEPTH = dssm_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [1:0]                          operation,
   input  wire logic [dssm_pkg::WORD_WIDTH-1:0]     push_value,
   output      logic                                cmd_valid,
   input  wire logic                                cmd_ready,
   output      dssm_pkg::ctrl_type                  cmd_ctrl,
   output      logic [$clog2(DEPTH)-1:0]            cmd_addr,
   output      logic [dssm_pkg::WORD_WIDTH-1:0]     cmd_word
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] lower_ff, lower_in;
   logic [CW-1:0] upper_ff, upper_in;
   logic [CW:0]   used;
   logic          full;
   logic          accept;
   logic [CW-1:0] top_addr;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   assign used = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign full = used >= (CW + 1)'(DEPTH);

   always_comb begin
      cmd_ctrl.kind   = dssm_pkg::KIND_NONE;
      cmd_ctrl.status = dssm_pkg::ST_DONE;
      cmd_addr        = '0;
      cmd_word        = '0;
      lower_in        = lower_ff;
      upper_in        = upper_ff;
      top_addr        = '0;
      unique case (dssm_pkg::op_type'(operation))
         dssm_pkg::OP_PUSH_ONE: begin
            if (full) begin
               cmd_ctrl.status = dssm_pkg::ST_FULL;
            end else begin
               cmd_ctrl.kind = dssm_pkg::KIND_WRITE;
               cmd_addr      = lower_ff[AW-1:0];
               cmd_word      = push_value;
               lower_in      = lower_ff + CW'(1);
            end
         end
         dssm_pkg::OP_PUSH_TWO: begin
            if (full) begin
               cmd_ctrl.status = dssm_pkg::ST_FULL;
            end else begin
               top_addr      = CW'(DEPTH - 1) - upper_ff;
               cmd_ctrl.kind = dssm_pkg::KIND_WRITE;
               cmd_addr      = top_addr[AW-1:0];
               cmd_word      = push_value;
               upper_in      = upper_ff + CW'(1);
            end
         end
         dssm_pkg::OP_POP_ONE: begin
            if (lower_ff == '0) begin
               cmd_ctrl.status = dssm_pkg::ST_EMPTY;
               cmd_word        = '1;
            end else begin
               top_addr      = lower_ff - CW'(1);
               cmd_ctrl.kind = dssm_pkg::KIND_READ;
               cmd_addr      = top_addr[AW-1:0];
               lower_in      = top_addr;
            end
         end
         dssm_pkg::OP_POP_TWO: begin
            if (upper_ff == '0) begin
               cmd_ctrl.status = dssm_pkg::ST_EMPTY;
               cmd_word        = '1;
            end else begin
               top_addr      = CW'(DEPTH) - upper_ff;
               cmd_ctrl.kind = dssm_pkg::KIND_READ;
               cmd_addr      = top_addr[AW-1:0];
               upper_in      = upper_ff - CW'(1);
            end
         end
         default: begin
            cmd_ctrl.kind = dssm_pkg::KIND_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else if (accept) begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   // stacks never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      used <= (CW + 1)'(DEPTH))
      else $error("stack counts exceed memory depth");

   // a refused or empty operation leaves both counts alone
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd_ctrl.status != dssm_pkg::ST_DONE)
      |=> ($stable(lower_ff) && $stable(upper_ff)))
      else $error("refused operation changed a stack count");

endmodule

`default_nettype wire

// ===== design/dssm_queue.sv =====
// Short command queue between front end and memory back end.
`default_nettype none

module dssm_queue #(
   parameter int WIDTH   = 8,
   parameter int DEPTH_Q = dssm_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      logic [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(DEPTH_Q);
   localparam int NW = $clog2(DEPTH_Q + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH_Q];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != NW'(DEPTH_Q);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH_Q - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH_Q - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH_Q))
      else $error("queue count out of range");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + NW'(1)))
      else $error("queue count did not track a lone push");

endmodule

`default_nettype wire

// ===== design/dssm_back.sv =====
// Back end: shared word memory and registered result stage.
`default_nettype none

module dssm_back #(
   parameter int DEPTH = dssm_pkg::DEFAULT_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_valid,
   output      logic                            cmd_ready,
   input  wire dssm_pkg::ctrl_type              cmd_ctrl,
   input  wire logic [$clog2(DEPTH)-1:0]        cmd_addr,
   input  wire logic [dssm_pkg::WORD_WIDTH-1:0] cmd_word,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [dssm_pkg::WORD_WIDTH-1:0] rsp_data,
   output      logic [1:0]                      rsp_status
);

   logic [dssm_pkg::WORD_WIDTH-1:0] mem [DEPTH];
   logic [dssm_pkg::WORD_WIDTH-1:0] rd_ff;
   logic [dssm_pkg::WORD_WIDTH-1:0] word_ff;
   dssm_pkg::ctrl_type              ctrl_ff;
   logic                            valid_ff;
   logic                            take;

   assign cmd_ready  = !valid_ff || rsp_ready;
   assign take       = cmd_valid && cmd_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_status = ctrl_ff.status;
   assign rsp_data   = (ctrl_ff.kind == dssm_pkg::KIND_READ) ? rd_ff : word_ff;

   always_ff @(posedge clock) begin
      if (take && cmd_ctrl.kind == dssm_pkg::KIND_WRITE) begin
         mem[cmd_addr] <= cmd_word;
      end
      if (take && cmd_ctrl.kind == dssm_pkg::KIND_READ) begin
         rd_ff <= mem[cmd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ctrl_ff <= cmd_ctrl;
         // pushes report zero
         word_ff <= (cmd_ctrl.kind == dssm_pkg::KIND_WRITE) ? '0 : cmd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== design/dual_stack_shared_memory.sv =====
// Top level: two stacks sharing one word memory, front end, queue and back end.
//
// Two stacks live in one memory of DEPTH 32-bit words: stack one grows up from
// address 0, stack two grows down from address DEPTH-1. Each item on the req
// channel carries an operation in req_tuser (push one, push two, pop one, pop
// two) and a push word in req_tdata; every item gives exactly one result with
// the popped word in rsp_tdata and a status in rsp_tuser (done, full push
// refused, empty pop with data all ones). The front end keeps both stack counts
// and decides each operation in the cycle it is accepted; a short command queue
// feeds the back end, which makes the single memory access and registers the
// result. With rsp_tready high, one item per cycle is sustained, set by the one
// memory access each item makes; rsp_tvalid rises once the item has passed
// through the queue entry and the back end's registered result stage.
// Memory contents are not cleared at reset and need no clearing.
`default_nettype none

module dual_stack_shared_memory #(
   parameter int DEPTH   = dssm_pkg::DEFAULT_DEPTH,
   parameter int DEPTH_Q = dssm_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] push_value
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [31:0] pop_data
   output      logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(DEPTH);
   localparam int WW = dssm_pkg::WORD_WIDTH;
   localparam int QW = AW + WW + dssm_pkg::CTRL_WIDTH;

   logic               fe_valid, fe_ready;
   dssm_pkg::ctrl_type fe_ctrl;
   logic [AW-1:0]      fe_addr;
   logic [WW-1:0]      fe_word;
   logic               be_valid, be_ready;
   logic [QW-1:0]      be_pack;
   dssm_pkg::ctrl_type be_ctrl;
   logic [AW-1:0]      be_addr;
   logic [WW-1:0]      be_word;

   dssm_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .operation  (req_tuser),
      .push_value (req_tdata),
      .cmd_valid  (fe_valid),
      .cmd_ready  (fe_ready),
      .cmd_ctrl   (fe_ctrl),
      .cmd_addr   (fe_addr),
      .cmd_word   (fe_word)
   );

   dssm_queue #(.WIDTH(QW), .DEPTH_Q(DEPTH_Q)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   ({fe_addr, fe_word, fe_ctrl}),
      .out_valid (be_valid),
      .out_ready (be_ready),
      .out_data  (be_pack)
   );

   assign be_ctrl = dssm_pkg::ctrl_type'(be_pack[dssm_pkg::CTRL_WIDTH-1:0]);
   assign be_word = be_pack[dssm_pkg::CTRL_WIDTH +: WW];
   assign be_addr = be_pack[dssm_pkg::CTRL_WIDTH + WW +: AW];

   dssm_back #(.DEPTH(DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (be_valid),
      .cmd_ready  (be_ready),
      .cmd_ctrl   (be_ctrl),
      .cmd_addr   (be_addr),
      .cmd_word   (be_word),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the dual stack shared memory block.
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int STORE_DEPTH = dssm_pkg::DEFAULT_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 12;

   // Mirror of both stacks; predicts one result per accepted item.
   class stack_scoreboard;
      bit [31:0]            words [STORE_DEPTH];
      int unsigned          lower_count = 0;
      int unsigned          upper_count = 0;
      bit [31:0]            expected_data [$];
      dssm_pkg::status_type expected_status [$];
      int unsigned          mismatches = 0;

      function void note_request(dssm_pkg::op_type op, bit [31:0] value);
         bit [31:0]            data;
         dssm_pkg::status_type status;
         bit                   full;
         data   = '0;
         status = dssm_pkg::ST_DONE;
         full   = (lower_count + upper_count) >= STORE_DEPTH;
         case (op)
            dssm_pkg::OP_PUSH_ONE: begin
               if (full) begin
                  status = dssm_pkg::ST_FULL;
               end else begin
                  words[lower_count] = value;
                  lower_count++;
               end
            end
            dssm_pkg::OP_PUSH_TWO: begin
               if (full) begin
                  status = dssm_pkg::ST_FULL;
               end else begin
                  upper_count++;
                  words[STORE_DEPTH - upper_count] = value;
               end
            end
            dssm_pkg::OP_POP_ONE: begin
               if (lower_count == 0) begin
                  data   = '1;
                  status = dssm_pkg::ST_EMPTY;
               end else begin
                  lower_count--;
                  data = words[lower_count];
               end
            end
            default: begin
               if (upper_count == 0) begin
                  data   = '1;
                  status = dssm_pkg::ST_EMPTY;
               end else begin
                  data = words[STORE_DEPTH - upper_count];
                  upper_count--;
               end
            end
         endcase
         expected_data.push_back(data);
         expected_status.push_back(status);
      endfunction

      function void check_result(bit [31:0] data, logic [1:0] status);
         bit [31:0]            want_data;
         dssm_pkg::status_type want_status;
         if (expected_data.size() == 0) begin
            $display("%0t: unexpected item, data %h status %0d", $time, data, status);
            mismatches++;
            return;
         end
         want_data   = expected_data.pop_front();
         want_status = expected_status.pop_front();
         if (data !== want_data) begin
            $display("%0t: pop_data expected %h got %h", $time, want_data, data);
            mismatches++;
         end
         if (status !== want_status) begin
            $display("%0t: status expected %0d got %0d", $time, want_status, status);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_data.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = dssm_pkg::OP_PUSH_ONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   stack_scoreboard board;
   bit              steady = 1'b0;   // no gaps on either side while set
   int              rsp_hold = 0;
   int unsigned     cycle_count = 0;

   dual_stack_shared_memory #(
      .DEPTH(STORE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(negedge clock) begin
      if (steady) begin
         rsp_tready = 1'b1;
         rsp_hold   = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready = 1'b0;
      end else begin
         rsp_hold = pick_gap();
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_item(input dssm_pkg::op_type op, input logic [31:0] value);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, value);
   endtask

   // hold off the sender until every outstanding item has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_mix(input int count, input int push_pct);
      dssm_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? dssm_pkg::OP_PUSH_TWO : dssm_pkg::OP_PUSH_ONE;
         else
            op = $urandom_range(0, 1) ? dssm_pkg::OP_POP_TWO : dssm_pkg::OP_POP_ONE;
         send_item(op, $urandom);
      end
   endtask

   initial begin
      board = new;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty pops, extreme words on both stacks, LIFO order per stack
      send_item(dssm_pkg::OP_POP_ONE, 32'h0000_0000);
      send_item(dssm_pkg::OP_POP_TWO, 32'hFFFF_FFFF);
      send_item(dssm_pkg::OP_PUSH_ONE, 32'h0000_0000);
      send_item(dssm_pkg::OP_PUSH_ONE, 32'h7FFF_FFFF);
      send_item(dssm_pkg::OP_PUSH_TWO, 32'h8000_0000);
      send_item(dssm_pkg::OP_PUSH_TWO, 32'hFFFF_FFFF);
      send_item(dssm_pkg::OP_PUSH_ONE, 32'hFFFF_FFFF);
      send_item(dssm_pkg::OP_PUSH_TWO, 32'h0000_0000);
      send_item(dssm_pkg::OP_PUSH_ONE, 32'hA5A5_A5A5);
      send_item(dssm_pkg::OP_PUSH_TWO, 32'h5A5A_5A5A);
      repeat (4) send_item(dssm_pkg::OP_POP_ONE, 32'h1234_5678);
      repeat (4) send_item(dssm_pkg::OP_POP_TWO, 32'h8765_4321);
      send_item(dssm_pkg::OP_POP_ONE, 32'h0000_0001);
      send_item(dssm_pkg::OP_POP_TWO, 32'h8000_0001);
      send_item(dssm_pkg::OP_PUSH_TWO, 32'h1234_5678);
      send_item(dssm_pkg::OP_POP_TWO, 32'h0000_0000);
      wait_for_drain();

      // pushes only, past the point where the stacks meet, so full pushes get refused
      run_mix(264, 100);
      wait_for_drain();
      steady = 1'b1;
      run_mix(40, 50);
      steady = 1'b0;
      // drain both stacks toward empty
      run_mix(240, 3);
      wait_for_drain();
      run_mix(20, 60);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
